// ----- rtl/srt_pkg.sv -----
// Package for the service routing table: request codes, entry kinds, status codes.
// No dependencies.
package srt_pkg;
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int ALIAS_BYTES_DEF = 16;

	typedef enum logic [3:0] {
		REQ_CLEAR = 4'd0, REQ_ADD_NODE = 4'd1, REQ_ADD_SVC = 4'd2, REQ_RM_SVC = 4'd3,
		REQ_RM_NODE = 4'd4, REQ_ID_OF_ALIAS = 4'd5, REQ_ALIAS_OF_ID = 4'd6,
		REQ_NODE_OF_SVC = 4'd7, REQ_LARGEST = 4'd8
	} req_t;

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0, KIND_NODE = 2'd1, KIND_SERVICE = 2'd2
	} kind_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		kind_t kind;
		logic [15:0] key;
		logic [7:0] typ;
		logic [63:0] alo;
		logic [63:0] ahi;
	} entry_t;
endpackage

// ----- rtl/srt_alias_cmp.sv -----
// Alias compare: bytes equal up to the first shared zero byte or ALIAS_BYTES.
// Depends on srt_pkg.
module srt_alias_cmp #(
	parameter int ALIAS_BYTES = srt_pkg::ALIAS_BYTES_DEF
) (
	input  logic [127:0] a,
	input  logic [127:0] b,
	output logic         match
);
	import srt_pkg::*;
	logic [15:0] diff;
	logic [15:0] zero;
	logic [15:0] stop;

	// per-byte flags, then a prefix scan of independent bytes
	always_comb begin
		for (int k = 0; k < 16; k++) begin
			diff[k] = (k < ALIAS_BYTES) && (a[8*k +: 8] != b[8*k +: 8]);
			zero[k] = (k < ALIAS_BYTES) && (a[8*k +: 8] == 8'h00);
		end
		// a mismatch counts unless an earlier shared zero ended the compare
		stop[0] = 1'b0;
		for (int k = 1; k < 16; k++)
			stop[k] = stop[k-1] | (zero[k-1] & ~diff[k-1]);
		match = ~|(diff & ~stop);
	end
endmodule

// ----- rtl/service_routing_table.sv -----
// Service routing table top level: request sequencer, entry memory, scan unit.
// Depends on srt_pkg and srt_alias_cmp.
//
// Usage: a request enters on the in channel (in_valid / in_stall) with req_type,
// ids, type code and alias; one result leaves on the out channel
// (out_valid / out_stall). The block takes one request at a time: in_stall
// is high from acceptance until the result is taken.
// Scanning: lookups and removals scan the occupied entries through one memory
// read port, one entry per cycle, and the read data is registered. Adds and
// clear do not scan. Removals also shift each later entry down one slot, with
// a read state and then a write state per entry. Removing a node shifts the
// whole run of services out in one pass rather than one service at a time.
// Reset clears only the count and control state; memory beyond the count is never
// read, so no clearing pass runs. When the receiver stalls, the result holds
// in its output register and no new request is taken.
module service_routing_table #(
	parameter int TABLE_DEPTH = srt_pkg::TABLE_DEPTH_DEF,
	parameter int ALIAS_BYTES = srt_pkg::ALIAS_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  req_type,
	input  logic [15:0] service_id,
	input  logic [15:0] node_id,
	input  logic [7:0]  service_type,
	input  logic [63:0] alias_low,
	input  logic [63:0] alias_high,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] found_service_id,
	output logic [15:0] found_node_id,
	output logic [63:0] found_alias_low,
	output logic [63:0] found_alias_high,
	output logic [6:0]  entries_used
);
	import srt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_FIND, S_SHIFT_RD, S_SHIFT_WR, S_DONE
	} state_t;

	// Mask of stored alias bytes.
	function automatic logic [127:0] alias_mask();
		logic [127:0] m;
		m = '0;
		for (int k = 0; k < 16; k++)
			if (k < ALIAS_BYTES) m[8*k +: 8] = 8'hFF;
		return m;
	endfunction

	state_t      state_q;
	logic [CW-1:0] count_q;
	req_t        req_q;
	logic [15:0] sid_q, nid_q;
	logic [7:0]  typ_q;
	logic [127:0] alias_q;

	// memory
	entry_t      mem [TABLE_DEPTH];
	logic        we;
	logic [AW-1:0] waddr, raddr;
	entry_t      wdata, rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// scan control
	logic [CW-1:0] ridx_q;     // next index to read
	logic [CW-1:0] cidx_q;     // index of rdata_q
	logic          rvalid_q;   // rdata_q holds entry cidx_q
	logic [CW-1:0] hit_q;      // found index (removal start)
	logic [CW-1:0] rm_end_q;   // first index kept after a removal run
	logic [CW-1:0] src_q;      // shift source index
	logic [15:0]   last_node_q;
	logic          have_node_q;

	logic [1:0]  st_q;
	logic [15:0] fsid_q, fnid_q;
	logic [63:0] falo_q, fahi_q;
	logic        ovalid_q;

	logic alias_hit;
	srt_alias_cmp #(.ALIAS_BYTES(ALIAS_BYTES)) u_cmp (
		.a    ({rdata_q.ahi, rdata_q.alo}),
		.b    (alias_q),
		.match(alias_hit)
	);

	logic is_svc_hit, is_node_hit;
	assign is_svc_hit  = rdata_q.kind == KIND_SERVICE && rdata_q.key == sid_q;
	assign is_node_hit = rdata_q.kind == KIND_NODE && rdata_q.key == nid_q;

	assign in_stall         = state_q != S_IDLE;
	assign out_valid        = ovalid_q;
	assign status           = st_q;
	assign found_service_id = fsid_q;
	assign found_node_id    = fnid_q;
	assign found_alias_low  = falo_q;
	assign found_alias_high = fahi_q;
	assign entries_used     = 7'(count_q);

	always_comb begin
		we    = 1'b0;
		waddr = AW'(count_q);
		wdata = '{kind: KIND_SERVICE, key: sid_q, typ: typ_q,
			alo: alias_q[63:0], ahi: alias_q[127:64]};
		raddr = AW'(ridx_q);
		if (state_q == S_DONE && !ovalid_q &&
				(req_q == REQ_ADD_NODE || req_q == REQ_ADD_SVC) &&
				count_q < CW'(TABLE_DEPTH)) begin
			we = 1'b1;
			if (req_q == REQ_ADD_NODE)
				wdata = '{kind: KIND_NODE, key: nid_q, typ: 8'h00, alo: '0, ahi: '0};
		end
		if (state_q == S_SHIFT_RD) raddr = AW'(src_q);
		if (state_q == S_SHIFT_WR) begin
			we    = 1'b1;
			waddr = AW'(hit_q);
			wdata = rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ovalid_q <= 1'b0;
			rvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
					if (in_valid) begin
						req_q   <= req_t'(req_type);
						sid_q   <= service_id;
						nid_q   <= node_id;
						typ_q   <= service_type;
						alias_q <= {alias_high, alias_low} & alias_mask();
						ridx_q  <= '0;
						rvalid_q <= 1'b0;
						have_node_q <= 1'b0;
						last_node_q <= '0;
						st_q   <= ST_OK;
						fsid_q <= '0;
						fnid_q <= '0;
						falo_q <= '0;
						fahi_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// advance the read pointer; evaluate the entry read last cycle
					rvalid_q <= ridx_q < count_q;
					cidx_q   <= ridx_q;
					if (ridx_q < count_q) ridx_q <= ridx_q + 1'b1;
					if (req_q != REQ_ID_OF_ALIAS && req_q != REQ_ALIAS_OF_ID &&
							req_q != REQ_NODE_OF_SVC && req_q != REQ_LARGEST &&
							req_q != REQ_RM_SVC && req_q != REQ_RM_NODE)
						state_q <= S_DONE;
					else if (rvalid_q) begin
						priority case (req_q)
							REQ_LARGEST: begin
								if (rdata_q.kind == KIND_SERVICE && rdata_q.key > fsid_q)
									fsid_q <= rdata_q.key;
							end
							REQ_ID_OF_ALIAS: begin
								if (rdata_q.kind == KIND_SERVICE && alias_hit &&
										alias_q[7:0] != 8'hFF) begin
									fsid_q  <= rdata_q.key;
									state_q <= S_DONE;
									ovalid_q <= 1'b1;
								end
							end
							REQ_ALIAS_OF_ID: begin
								if (is_svc_hit) begin
									fsid_q <= sid_q;
									falo_q <= rdata_q.alo;
									fahi_q <= rdata_q.ahi;
									state_q <= S_DONE;
									ovalid_q <= 1'b1;
								end
							end
							REQ_NODE_OF_SVC: begin
								if (rdata_q.kind == KIND_NODE) begin
									have_node_q <= 1'b1;
									last_node_q <= rdata_q.key;
								end
								if (is_svc_hit) begin
									fsid_q <= sid_q;
									fnid_q <= have_node_q ? last_node_q : 16'h0;
									st_q   <= have_node_q ? ST_OK : ST_NOT_FOUND;
									state_q <= S_DONE;
									ovalid_q <= 1'b1;
								end
							end
							REQ_RM_SVC: begin
								if (is_svc_hit) begin
									hit_q    <= cidx_q;
									rm_end_q <= cidx_q + 1'b1;
									state_q  <= S_FIND;
								end
							end
							default: begin
								if (is_node_hit) begin
									hit_q    <= cidx_q + 1'b1;
									rm_end_q <= cidx_q + 1'b1;
									state_q  <= S_FIND;
								end
							end
						endcase
					end else if (ridx_q >= count_q && cidx_q == ridx_q - 1'b1 &&
							ridx_q != '0 || count_q == '0 || !(ridx_q < count_q) &&
							!rvalid_q && cidx_q == ridx_q) begin
						// scan exhausted with no match
						if (req_q != REQ_LARGEST) st_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
						ovalid_q <= 1'b1;
					end
				end
				S_FIND: begin
					// extend a node removal over the run of services after it
					if (req_q == REQ_RM_NODE && rdata_q.kind == KIND_SERVICE && rvalid_q &&
							cidx_q == rm_end_q) begin
						rm_end_q <= rm_end_q + 1'b1;
						rvalid_q <= ridx_q < count_q;
						cidx_q   <= ridx_q;
						if (ridx_q < count_q) ridx_q <= ridx_q + 1'b1;
					end else if (req_q == REQ_RM_NODE && !rvalid_q && cidx_q != rm_end_q &&
							rm_end_q < count_q) begin
						rvalid_q <= 1'b1;
						cidx_q   <= ridx_q;
						ridx_q   <= ridx_q + 1'b1;
					end else begin
						src_q   <= rm_end_q;
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					if (src_q < count_q) begin
						src_q   <= src_q + 1'b1;
						state_q <= S_SHIFT_WR;
					end else begin
						count_q  <= hit_q;
						state_q  <= S_DONE;
						ovalid_q <= 1'b1;
					end
				end
				S_SHIFT_WR: begin
					hit_q   <= hit_q + 1'b1;
					state_q <= S_SHIFT_RD;
				end
				default: begin
					// S_DONE: finish writes, then hold the result until taken
					if (!ovalid_q) begin
						priority case (req_q)
							REQ_CLEAR: count_q <= '0;
							REQ_ADD_NODE, REQ_ADD_SVC: begin
								if (count_q < CW'(TABLE_DEPTH)) count_q <= count_q + 1'b1;
								else st_q <= ST_FULL;
							end
							default: st_q <= ST_NOT_FOUND;
						endcase
						ovalid_q <= 1'b1;
					end else if (!out_stall) begin
						ovalid_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
			endcase
		end
	end
endmodule
